>>> rtl/qpte_pkg.sv
`timescale 1ns / 1ps

package qpte_pkg;

  localparam int KEY_W       = 62;   // interleaved key at the highest zoom
  localparam int PREV_W      = 63;   // key store, room for the sentinel bit
  localparam int COORD_W     = 31;   // one tile axis at zoom 31
  localparam int ZOOM_W      = 5;
  localparam int TZOOM_W     = 6;    // reported zoom, room for the +3 offset
  localparam int TCOORD_W    = 34;   // reported axis, room for the x8 scale
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 80;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam int ZOOM_LIMIT_DEF = 31;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ZOOM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ZOOM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SCALE = 2'd2;

  localparam logic [ZOOM_W-1:0] RST_MAX_ZOOM = 5'd18;
  localparam logic [ZOOM_W-1:0] RST_MIN_ZOOM = 5'd0;

  // zoom offset and coordinate shift of the scaled report
  localparam logic [TZOOM_W-1:0] SCALE_ZOOM_ADD = 6'd3;
  localparam int                 SCALE_SHIFT    = 3;

  localparam logic [TZOOM_W-1:0] TZOOM_MAX = 6'd34;

endpackage

>>> rtl/quadkey_parent_tile_expander.sv
`timescale 1ns / 1ps
// Quadkey parent tile expander.
// Input stream (in_*): one word per quadkey, tdata[61:0] holds the key at the
// configured highest zoom (y bit above x bit per level), tuser flags the start
// of a new sorted list. Output stream (out_*): one word per reported tile,
// tdata holds zoom, column and row; tlast marks the final tile of a key.
// Configuration (cfg_*): index 0 highest zoom, 1 lowest zoom, 2 scaled report
// (x8 coordinates, zoom+3). Always ready; write only while the block is idle.
// Timing: after a key is taken, one shared compare/shift step per cycle, while
// the output register is free, walks the levels from the highest zoom down.
// The input stays closed until the walk ends, so a new key is taken only once
// the last one is through. Each step is one 63-bit compare and a 2-bit shift
// of the key and of the stored previous key. The first tile passes the pending
// tile register and then the output register after the key is taken.
// Reset: registers return to zoom 18 / 0 / plain report, the stored previous
// key to the sentinel 2^36, and both streams go idle.
// Stall: a stalled output holds its word; the step loop waits until the output
// register is free, so no tile is lost or repeated.
module quadkey_parent_tile_expander
  import qpte_pkg::*;
#(
  parameter int ZOOM_LIMIT = ZOOM_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in: [61:0] quadkey, [63:62] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in: [0] start_of_list
  input  logic                  in_tuser,
  // out: [5:0] tile_zoom, [39:6] tile_x, [73:40] tile_y, [79:74] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_of_run
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [ZOOM_W-1:0] ZLIM = ZOOM_W'(ZOOM_LIMIT);

  // configuration
  logic [ZOOM_W-1:0] max_zoom_r;
  logic [ZOOM_W-1:0] min_zoom_r;
  logic              scale_r;

  // sequencer
  logic              state_r,   state_nxt;
  logic [KEY_W-1:0]  key_r,     key_nxt;      // current parent of the key
  logic [PREV_W-1:0] cmp_r,     cmp_nxt;      // previous key at the same level
  logic [PREV_W-1:0] prev_key_r, prev_key_nxt;
  logic [ZOOM_W-1:0] lvl_r,     lvl_nxt;
  logic              in_range_r, in_range_nxt;
  logic              pend_r,    pend_nxt;     // a tile waits for its tlast
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic [ZOOM_W-1:0] pend_zoom_r, pend_zoom_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r,  out_data_nxt;
  logic                  out_last_r,  out_last_nxt;

  logic              in_acc;
  logic              step_en;
  logic              hit;
  logic [ZOOM_W-1:0] eff_mz;
  logic [5:0]        key_bits;
  logic [PREV_W-1:0] sentinel;
  logic [PREV_W-1:0] mask;
  logic [KEY_W-1:0]  key_in;
  logic [COORD_W-1:0] px, py;
  logic [TCOORD_W-1:0] tx, ty;
  logic [TZOOM_W-1:0]  tz;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // clamp the highest zoom, build the sentinel and the key mask
  assign eff_mz   = (max_zoom_r > ZLIM) ? ZLIM : max_zoom_r;
  assign key_bits = {eff_mz, 1'b0};
  assign sentinel = PREV_W'(1) << key_bits;
  assign mask     = sentinel - PREV_W'(1);
  assign key_in   = in_tdata[KEY_W-1:0] & mask[KEY_W-1:0];

  // a level is reported while its parent differs from the previous key's
  assign hit     = in_range_r && ({1'b0, key_r} != cmp_r);
  assign step_en = !out_valid_r || out_tready;

  // split the waiting parent into column and row
  always_comb begin
    for (int i = 0; i < COORD_W; i++) begin
      px[i] = pend_key_r[2*i];
      py[i] = pend_key_r[2*i+1];
    end
  end

  always_comb begin
    if (scale_r) begin
      tx = {px, SCALE_SHIFT'(0)};
      ty = {py, SCALE_SHIFT'(0)};
      tz = TZOOM_W'(pend_zoom_r) + SCALE_ZOOM_ADD;
    end else begin
      tx = TCOORD_W'(px);
      ty = TCOORD_W'(py);
      tz = TZOOM_W'(pend_zoom_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    cmp_nxt       = cmp_r;
    prev_key_nxt  = prev_key_r;
    lvl_nxt       = lvl_r;
    in_range_nxt  = in_range_r;
    pend_nxt      = pend_r;
    pend_key_nxt  = pend_key_r;
    pend_zoom_nxt = pend_zoom_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt      = key_in;
          cmp_nxt      = in_tuser ? sentinel : prev_key_r;
          prev_key_nxt = PREV_W'(key_in);
          lvl_nxt      = eff_mz;
          in_range_nxt = (min_zoom_r <= eff_mz);
          pend_nxt     = 1'b0;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_en) begin
          // flush the waiting tile; it is the last one unless this level hits
          if (pend_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = OUT_DATA_W'({ty, tx, tz});
            out_last_nxt  = !hit;
          end
          if (hit) begin
            pend_nxt      = 1'b1;
            pend_key_nxt  = key_r;
            pend_zoom_nxt = lvl_r;
            key_nxt       = key_r >> 2;
            cmp_nxt       = cmp_r >> 2;
            lvl_nxt       = lvl_r - ZOOM_W'(1);
            in_range_nxt  = (lvl_r != min_zoom_r);
          end else begin
            // coarser levels match as well, or lie below the lowest zoom: drop the rest
            pend_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_zoom_r  <= RST_MAX_ZOOM;
      min_zoom_r  <= RST_MIN_ZOOM;
      scale_r     <= 1'b0;
      state_r     <= ST_IDLE;
      prev_key_r  <= PREV_W'(1) << {RST_MAX_ZOOM, 1'b0};
      pend_r      <= 1'b0;
      in_range_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_ZOOM:   max_zoom_r <= cfg_data[ZOOM_W-1:0];
          REG_MIN_ZOOM:   min_zoom_r <= cfg_data[ZOOM_W-1:0];
          REG_TILE_SCALE: scale_r    <= cfg_data[0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      prev_key_r  <= prev_key_nxt;
      pend_r      <= pend_nxt;
      in_range_r  <= in_range_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    cmp_r       <= cmp_nxt;
    lvl_r       <= lvl_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_zoom_r <= pend_zoom_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

>>> rtl/qpte_checker.sv
`timescale 1ns / 1ps

module qpte_checker
  import qpte_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // one key at a time: input closes after a key is taken
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input stayed open after a key");

  // nothing leaves right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reported zoom stays within range
  a_zoom_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TZOOM_W-1:0] <= TZOOM_MAX)
    else $error("reported zoom out of range");

endmodule

bind quadkey_parent_tile_expander qpte_checker u_qpte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
